### design/rbst_pkg.sv
// Package for the ray against box slab test: types, register codes and the
// fp32 arithmetic helpers shared by the subtractor, multiplier and slab cells.
// Depends on nothing.
`default_nettype none

package rbst_pkg;

  localparam int NumAxes = 3;
  localparam logic [31:0] FpQnan = 32'h7FC0_0000;
  localparam logic [31:0] FpZero = 32'h0000_0000;
  localparam logic [31:0] FpMaxFinite = 32'h7F7F_FFFF;

  typedef enum logic [2:0] {
    RegOriginX,
    RegOriginY,
    RegOriginZ,
    RegInvX,
    RegInvY,
    RegInvZ,
    RegLength,
    RegParallel
  } cfg_reg_e;

  typedef struct packed {
    logic [NumAxes-1:0][31:0] bmin;
    logic [NumAxes-1:0][31:0] bmax;
    logic                     hit;
    logic [31:0]              t_entry;
    logic [31:0]              t_exit;
  } slab_t;

  typedef struct packed {
    logic        special;
    logic [31:0] sp_val;
    logic        sign;
    logic        eff_sub;
    logic [8:0]  exp;
    logic [27:0] man;
  } fadd_mid_t;

  typedef struct packed {
    logic        special;
    logic [31:0] sp_val;
    logic        sign;
    logic [10:0] exp;
    logic [47:0] prod;
  } fmul_mid_t;

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (&a[30:23]) & (|a[22:0]);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] a);
    return (&a[30:23]) & ~(|a[22:0]);
  endfunction

  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    return !(fp_is_nan(a) | fp_is_nan(b)) &&
           !((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) && (ka < kb);
  endfunction

  // Alignment and wide add of a + b, with guard, round and sticky bits.
  function automatic fadd_mid_t fadd_align(input logic [31:0] a, input logic [31:0] b);
    fadd_mid_t   r;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [26:0] mx;
    logic [26:0] my;
    logic [26:0] sh;
    logic [26:0] lost;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {|x[30:23], x[22:0], 3'b000};
    my = {|y[30:23], y[22:0], 3'b000};
    d = ex - ey;
    if (d >= 8'd27) begin
      sh = '0;
      lost = my;
    end else begin
      sh = my >> d;
      lost = my & ((27'd1 << d) - 27'd1);
    end
    sh[0] = sh[0] | (|lost);
    r.special = 1'b0;
    r.sp_val = FpZero;
    r.sign = x[31];
    r.eff_sub = x[31] ^ y[31];
    r.exp = {1'b0, ex};
    r.man = r.eff_sub ? ({1'b0, mx} - {1'b0, sh}) : ({1'b0, mx} + {1'b0, sh});
    priority if (fp_is_nan(a) || fp_is_nan(b)) begin
      r.special = 1'b1;
      r.sp_val = FpQnan;
    end else if (fp_is_inf(a) && fp_is_inf(b)) begin
      r.special = 1'b1;
      r.sp_val = r.eff_sub ? FpQnan : a;
    end else if (fp_is_inf(a)) begin
      r.special = 1'b1;
      r.sp_val = a;
    end else if (fp_is_inf(b)) begin
      r.special = 1'b1;
      r.sp_val = b;
    end else begin
      r.special = 1'b0;
    end
    return r;
  endfunction

  // Normalization and round to nearest even of the aligned sum.
  function automatic logic [31:0] fadd_round(input fadd_mid_t m);
    logic [27:0] n;
    logic [8:0]  e;
    logic [8:0]  lim;
    logic [4:0]  lz;
    logic [4:0]  shamt;
    logic [7:0]  ef;
    logic        rnd;
    logic        sgn;
    logic [30:0] body;
    logic [31:0] res;
    int          i;
    lz = 5'd27;
    shamt = '0;
    for (i = 0; i < 27; i++) begin
      if (m.man[i]) lz = 5'(26 - i);
    end
    lim = m.exp - 9'd1;
    if (m.man[27]) begin
      n = {1'b0, m.man[27:2], m.man[1] | m.man[0]};
      e = m.exp + 9'd1;
    end else begin
      shamt = ({4'b0, lz} < lim) ? lz : lim[4:0];
      n = m.man << shamt;
      e = m.exp - {4'b0, shamt};
    end
    sgn = ((m.man == 28'd0) && m.eff_sub) ? 1'b0 : m.sign;
    ef = n[26] ? e[7:0] : 8'd0;
    body = {ef, n[25:3]};
    rnd = n[2] & (n[1] | n[0] | n[3]);
    if (m.special) begin
      res = m.sp_val;
    end else if (e >= 9'd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      res = {sgn, body + 31'(rnd)};
    end
    return res;
  endfunction

  function automatic fmul_mid_t fmul_prod(input logic [31:0] a, input logic [31:0] b);
    fmul_mid_t  r;
    logic [7:0] ea;
    logic [7:0] eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic       az;
    logic       bz;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    r.sign = a[31] ^ b[31];
    r.exp = {3'b0, ea} + {3'b0, eb} - 11'd127;
    r.prod = ma * mb;
    r.special = 1'b1;
    priority if (fp_is_nan(a) || fp_is_nan(b)) begin
      r.sp_val = FpQnan;
    end else if ((fp_is_inf(a) && bz) || (fp_is_inf(b) && az)) begin
      r.sp_val = FpQnan;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      r.sp_val = {r.sign, 8'hFF, 23'd0};
    end else if (az || bz) begin
      r.sp_val = {r.sign, 31'd0};
    end else begin
      r.special = 1'b0;
      r.sp_val = FpZero;
    end
    return r;
  endfunction

  // Leading one of the product moved to bit 47.
  function automatic fmul_mid_t fmul_norm(input fmul_mid_t m);
    fmul_mid_t  r;
    logic [5:0] lz;
    int         i;
    lz = 6'd0;
    for (i = 0; i < 48; i++) begin
      if (m.prod[i]) lz = 6'(47 - i);
    end
    r = m;
    r.prod = m.prod << lz;
    r.exp = m.exp + 11'd1 - {5'b0, lz};
    return r;
  endfunction

  function automatic logic [31:0] fmul_round(input fmul_mid_t m);
    logic [10:0] d;
    logic [47:0] q;
    logic [47:0] lost;
    logic [7:0]  ef;
    logic        rnd;
    logic [30:0] body;
    logic [31:0] res;
    d = 11'd1 - m.exp;
    if ($signed(m.exp) < 11'sd1) begin
      ef = 8'd0;
      if (d >= 11'd48) begin
        q = '0;
        lost = m.prod;
      end else begin
        q = m.prod >> d[5:0];
        lost = m.prod & ((48'd1 << d[5:0]) - 48'd1);
      end
    end else begin
      ef = m.exp[7:0];
      q = m.prod;
      lost = '0;
    end
    rnd = q[23] & ((|q[22:0]) | (|lost) | q[24]);
    body = {ef, q[46:24]};
    if (m.special) begin
      res = m.sp_val;
    end else if ($signed(m.exp) >= 11'sd255) begin
      res = {m.sign, 8'hFF, 23'd0};
    end else begin
      res = {m.sign, body + 31'(rnd)};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/rbst_fp_sub.sv
// Two-stage fp32 subtractor, y = a - b, round to nearest even.
// Depends on rbst_pkg.
`default_nettype none

module rbst_fp_sub (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] y_o
);
  import rbst_pkg::*;

  fadd_mid_t   mid_q;
  logic [31:0] y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= fadd_align(a_i, {~b_i[31], b_i[30:0]});
      y_q <= fadd_round(mid_q);
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

### design/rbst_fp_mul.sv
// Three-stage fp32 multiplier: product, normalization, rounding.
// Depends on rbst_pkg.
`default_nettype none

module rbst_fp_mul (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] y_o
);
  import rbst_pkg::*;

  fmul_mid_t   prod_q;
  fmul_mid_t   nrm_q;
  logic [31:0] y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= fmul_prod(a_i, b_i);
      nrm_q <= fmul_norm(prod_q);
      y_q <= fmul_round(nrm_q);
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

### design/rbst_cell.sv
// One slab cell: narrows the ray interval against the box slab of one axis
// and hands the box, rotated to the next axis, to its neighbor.
// Depends on rbst_pkg, rbst_fp_sub and rbst_fp_mul.
`default_nettype none

module rbst_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire rbst_pkg::slab_t data_i,
  input  wire logic [31:0]    origin_i,
  input  wire logic [31:0]    inv_dir_i,
  input  wire logic           parallel_i,
  output logic                valid_o,
  output rbst_pkg::slab_t     data_o
);
  import rbst_pkg::*;

  localparam int ArithLat = 5;

  logic [31:0]         dlo;
  logic [31:0]         dhi;
  logic [31:0]         t1;
  logic [31:0]         t2;
  logic [ArithLat-1:0] vld_q;
  slab_t               dly_q [ArithLat];
  slab_t               out_d;
  slab_t               out_q;
  logic                out_vld_q;

  rbst_fp_sub u_sub_lo (.clk_i, .en_i, .a_i(data_i.bmin[0]), .b_i(origin_i), .y_o(dlo));
  rbst_fp_sub u_sub_hi (.clk_i, .en_i, .a_i(data_i.bmax[0]), .b_i(origin_i), .y_o(dhi));
  rbst_fp_mul u_mul_lo (.clk_i, .en_i, .a_i(dlo), .b_i(inv_dir_i), .y_o(t1));
  rbst_fp_mul u_mul_hi (.clk_i, .en_i, .a_i(dhi), .b_i(inv_dir_i), .y_o(t2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[ArithLat-2:0], valid_i};
      out_vld_q <= vld_q[ArithLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= data_i;
      for (int k = 1; k < ArithLat; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    slab_t       cur;
    logic [31:0] near_t;
    logic [31:0] far_t;
    logic [31:0] ent;
    logic [31:0] ext;
    logic        swap;
    cur = dly_q[ArithLat-1];
    swap = fp_lt(t2, t1);
    near_t = swap ? t2 : t1;
    far_t = swap ? t1 : t2;
    ent = fp_lt(cur.t_entry, near_t) ? near_t : cur.t_entry;
    ext = fp_lt(far_t, cur.t_exit) ? far_t : cur.t_exit;
    out_d = cur;
    out_d.bmin = {cur.bmin[0], cur.bmin[NumAxes-1:1]};
    out_d.bmax = {cur.bmax[0], cur.bmax[NumAxes-1:1]};
    if (cur.hit) begin
      if (parallel_i) begin
        if (fp_lt(origin_i, cur.bmin[0]) || fp_lt(cur.bmax[0], origin_i)) begin
          out_d.hit = 1'b0;
        end
      end else begin
        out_d.t_entry = ent;
        out_d.t_exit = ext;
        if (fp_lt(ext, ent) || fp_lt(ext, FpZero)) begin
          out_d.hit = 1'b0;
        end
      end
    end
  end

  assign valid_o = out_vld_q;
  assign data_o = out_q;

endmodule

`default_nettype wire

### design/ray_box_slab_test.sv
// Top level of the fp32 ray against axis-aligned box slab test.
// Depends on rbst_pkg and rbst_cell.
//
// The ray is loaded through the configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i): origin, inverse direction, length and the mask of
// axes the ray runs parallel to. The user must load the ray only while no box
// is in flight; the block itself does not enforce this. The channel is always
// ready, and an index addresses the registers in that order. Boxes enter on
// in_valid_i / in_stall_o, one transaction per box, and each gives exactly one
// result transaction on out_valid_o / out_stall_i. Three slab cells in a row
// handle x, y and z; each cell has two subtractor stages, three multiplier
// stages and one compare stage. A new box is taken in every cycle in which the
// row is not stalled. When a valid result is stalled the whole row holds and
// in_stall_o is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, sets the ray length to the largest finite
// value and the other registers to zero.
`default_nettype none

module ray_box_slab_test (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] box_min_x_i,
  input  wire logic [31:0] box_min_y_i,
  input  wire logic [31:0] box_min_z_i,
  input  wire logic [31:0] box_max_x_i,
  input  wire logic [31:0] box_max_y_i,
  input  wire logic [31:0] box_max_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             hit_o,
  output logic      [31:0] entry_distance_o,
  output logic      [31:0] exit_distance_o
);
  import rbst_pkg::*;

  logic [NumAxes-1:0][31:0] origin_q;
  logic [NumAxes-1:0][31:0] inv_q;
  logic [31:0]              len_q;
  logic [NumAxes-1:0]       par_q;
  logic                     en;
  logic [NumAxes:0]         cv;
  slab_t                    cd [NumAxes+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      inv_q <= '0;
      len_q <= FpMaxFinite;
      par_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegOriginX:  origin_q[0] <= cfg_data_i;
        RegOriginY:  origin_q[1] <= cfg_data_i;
        RegOriginZ:  origin_q[2] <= cfg_data_i;
        RegInvX:     inv_q[0] <= cfg_data_i;
        RegInvY:     inv_q[1] <= cfg_data_i;
        RegInvZ:     inv_q[2] <= cfg_data_i;
        RegLength:   len_q <= cfg_data_i;
        RegParallel: par_q <= cfg_data_i[NumAxes-1:0];
        default:     par_q <= par_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign cv[0] = in_valid_i;
  always_comb begin
    cd[0].bmin = {box_min_z_i, box_min_y_i, box_min_x_i};
    cd[0].bmax = {box_max_z_i, box_max_y_i, box_max_x_i};
    cd[0].hit = 1'b1;
    cd[0].t_entry = FpZero;
    cd[0].t_exit = len_q;
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_cell
    rbst_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i      (en),
      .valid_i   (cv[g]),
      .data_i    (cd[g]),
      .origin_i  (origin_q[g]),
      .inv_dir_i (inv_q[g]),
      .parallel_i(par_q[g]),
      .valid_o   (cv[g+1]),
      .data_o    (cd[g+1])
    );
  end

  assign out_valid_o = cv[NumAxes];
  assign hit_o = cd[NumAxes].hit;
  assign entry_distance_o = cd[NumAxes].t_entry;
  assign exit_distance_o = cd[NumAxes].t_exit;

endmodule

`default_nettype wire

### design/rbst_checker.sv
// Port-level checks of the slab test, bound to the top level.
// Depends on rbst_pkg and ray_box_slab_test.
`default_nettype none

module rbst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        hit_o,
  input wire logic [31:0] entry_distance_o,
  input wire logic [31:0] exit_distance_o
);
  import rbst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(hit_o) && $stable(entry_distance_o) && $stable(exit_distance_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // A ray parallel to every axis can hit with a negative exit, so only a
  // non-negative exit is held against the entry.
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && !exit_distance_o[31] |->
      !fp_lt(exit_distance_o, entry_distance_o))
    else $error("hit reported with exit before entry");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk_i,
  .rst_ni,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .hit_o,
  .entry_distance_o,
  .exit_distance_o
);

`default_nettype wire
